@@ hdl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

  localparam int unsigned ModeWidth   = 3;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ModeWidth-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_PEEK_BACK  = 3'd4,
    MODE_PEEK_FRONT = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Shift commands broadcast to every cell; at most one is set in a cycle.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/deq_if.sv @@
`default_nettype none

interface deq_req_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::ModeWidth-1:0]    mode;
  logic [deq_pkg::WordWidth-1:0]    data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface deq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::WordWidth-1:0]    data_out;
  logic [deq_pkg::CountWidth-1:0]   item_count;
  logic [deq_pkg::StatusWidth-1:0]  status;

  modport source (output valid, output data_out, output item_count, output status,
                  input ready);
  modport sink   (input valid, input data_out, input item_count, input status,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/double_ended_queue.sv @@
`default_nettype none

// Double-ended queue of words built as a row of DEPTH slots.
//
// req_i carries one operation per transfer (push back/front, pop back/front,
// peek back/front, clear) with the word to push. rsp_o returns one transfer
// per operation: the word popped or peeked (zero otherwise), the number of
// stored words after the operation, and a status (ok, empty, full).
//
// Slot 0 always holds the front word; a front push shifts the whole row one
// slot toward the back, a front pop shifts it one slot toward the front, a
// back push fills the first empty slot and a back pop clears the last occupied
// slot. Every slot updates in the same cycle: the result appears in the
// output register in the cycle after the request transfer, and a new request
// is taken every cycle while the receiver takes each result as it is offered.
//
// A full push or an empty pop/peek leaves the queue unchanged and reports
// full or empty. Reset empties the queue at once (no clearing pass). While
// the receiver stalls a pending result, the request side holds ready low;
// it is released in the cycle the result transfers.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Request decode
  logic                  req_xfer;
  logic                  rsp_xfer;
  logic [63:0]           in_ext;
  logic [DATA_WIDTH-1:0] word;
  logic                  full;
  logic                  empty;
  deq_pkg::cell_ctl_t    ctl;

  // Slot row
  logic                  slot_valid [DEPTH];
  logic [DATA_WIDTH-1:0] slot_data  [DEPTH];
  logic [DATA_WIDTH-1:0] slot_tap   [DEPTH];
  logic [DEPTH-1:0]      valid_vec;
  logic [DATA_WIDTH-1:0] back_word;

  // Count and result
  logic [CW-1:0]                    count_q, count_d;
  logic [DATA_WIDTH-1:0]            res_word;
  deq_pkg::status_e                 res_status;
  logic [63:0]                      res_ext;
  logic [31:0]                      cnt_ext;
  logic                             rsp_valid_q;
  logic [deq_pkg::WordWidth-1:0]    rsp_data_q;
  logic [deq_pkg::CountWidth-1:0]   rsp_count_q;
  logic [deq_pkg::StatusWidth-1:0]  rsp_status_q;

  assign rsp_xfer    = rsp_valid_q & rsp_o.ready;
  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign req_xfer    = req_i.valid & req_i.ready;

  // Keep the low DATA_WIDTH bits of the pushed word.
  assign in_ext = 64'(req_i.data_in);
  assign word   = in_ext[DATA_WIDTH-1:0];

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // Command the row only for operations that change it.
  always_comb begin
    ctl = '0;
    if (req_xfer) begin
      unique case (req_i.mode)
        deq_pkg::MODE_PUSH_BACK:  ctl.push_back  = ~full;
        deq_pkg::MODE_PUSH_FRONT: ctl.push_front = ~full;
        deq_pkg::MODE_POP_BACK:   ctl.pop_back   = ~empty;
        deq_pkg::MODE_POP_FRONT:  ctl.pop_front  = ~empty;
        deq_pkg::MODE_CLEAR:      ctl.clear      = 1'b1;
        default:                  ctl            = '0;
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] left_data;
    logic                  right_valid;
    logic [DATA_WIDTH-1:0] right_data;

    // Slot 0 sees the incoming word as its left neighbor; the last slot
    // sees an empty slot to its right.
    if (k == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = word;
    end else begin : g_body
      assign left_valid = slot_valid[k-1];
      assign left_data  = slot_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = slot_valid[k+1];
      assign right_data  = slot_data[k+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .word_i        (word),
      .left_valid_i  (left_valid),
      .left_data_i   (left_data),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (slot_valid[k]),
      .data_o        (slot_data[k]),
      .back_tap_o    (slot_tap[k])
    );

    assign valid_vec[k] = slot_valid[k];
  end

  // Only the last occupied slot drives its tap, so OR the taps together.
  always_comb begin
    back_word = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      back_word = back_word | slot_tap[k];
    end
  end

  // Next count, returned word and status.
  always_comb begin
    count_d    = count_q;
    res_word   = '0;
    res_status = deq_pkg::STATUS_OK;
    unique case (req_i.mode)
      deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          res_status = deq_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::MODE_POP_BACK, deq_pkg::MODE_PEEK_BACK: begin
        if (empty) begin
          res_status = deq_pkg::STATUS_EMPTY;
        end else begin
          res_word = back_word;
          if (req_i.mode == deq_pkg::MODE_POP_BACK) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_PEEK_FRONT: begin
        if (empty) begin
          res_status = deq_pkg::STATUS_EMPTY;
        end else begin
          res_word = slot_data[0];
          if (req_i.mode == deq_pkg::MODE_POP_FRONT) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      deq_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign res_ext = 64'(res_word);
  assign cnt_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_xfer) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_xfer) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it transfers.
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      rsp_data_q   <= res_ext[deq_pkg::WordWidth-1:0];
      rsp_count_q  <= cnt_ext[deq_pkg::CountWidth-1:0];
      rsp_status_q <= res_status;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.data_out   = rsp_data_q;
  assign rsp_o.item_count = rsp_count_q;
  assign rsp_o.status     = rsp_status_q;

  // The occupied slots always number exactly the stored count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("slot occupancy disagrees with count");

  // The count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count above depth");

  // A push into a full queue leaves the count alone and reports full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && full && (req_i.mode == deq_pkg::MODE_PUSH_BACK ||
                          req_i.mode == deq_pkg::MODE_PUSH_FRONT))
    |=> ($stable(count_q) && rsp_status_q == deq_pkg::STATUS_FULL))
    else $error("full push altered the queue");

  // Every request transfer leaves a result pending in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> rsp_valid_q)
    else $error("result lost");

endmodule

`default_nettype wire

@@ hdl/deq_cell.sv @@
`default_nettype none

// One queue slot. Takes its left neighbor on a front push, its right neighbor
// on a front pop, the new word when it is the first empty slot on a back push.
module deq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire deq_pkg::cell_ctl_t    ctl_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic                  left_valid_i,
  input  wire logic [DATA_WIDTH-1:0] left_data_i,
  input  wire logic                  right_valid_i,
  input  wire logic [DATA_WIDTH-1:0] right_data_i,
  output logic                       valid_o,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic [DATA_WIDTH-1:0]      back_tap_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  is_last;

  assign is_last = valid_q & ~right_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (ctl_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctl_i.push_back) begin
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        data_d  = word_i;
      end
    end else if (ctl_i.pop_back) begin
      if (is_last) begin
        valid_d = 1'b0;
      end
    end else begin
      // Hold the slot.
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o    = valid_q;
  assign data_o     = data_q;
  assign back_tap_o = is_last ? data_q : '0;

endmodule

`default_nettype wire
